/* rtl/core/owbm_pkg.sv */
// shared types, register map and constants of the one-wire bus master
package owbm_pkg;

	localparam int NUM_REGS        = 8;
	localparam int REG_W           = 10;
	localparam int ADDR_W          = 5;
	localparam int COUNT_WIDTH_DEF = 10;
	localparam int GAP_TICKS       = 5;

	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 16;

	localparam logic [2:0] REG_RESET_LOW    = 3'd0;
	localparam logic [2:0] REG_PRESENCE_SMP = 3'd1;
	localparam logic [2:0] REG_RESET_REC    = 3'd2;
	localparam logic [2:0] REG_READ_LOW     = 3'd3;
	localparam logic [2:0] REG_READ_SMP     = 3'd4;
	localparam logic [2:0] REG_READ_REC     = 3'd5;
	localparam logic [2:0] REG_WRITE_SHORT  = 3'd6;
	localparam logic [2:0] REG_WRITE_LONG   = 3'd7;

	localparam logic [1:0] FUNC_RESET = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	typedef logic [REG_W-1:0] reg_word_t;

	localparam reg_word_t REG_DEFAULTS [NUM_REGS] = '{
		10'd485, 10'd65, 10'd500, 10'd2, 10'd13, 10'd45, 10'd3, 10'd65
	};

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_RST_REC  = 4'd3,
		PH_RD_LOW   = 4'd4,
		PH_RD_WAIT  = 4'd5,
		PH_RD_REC   = 4'd6,
		PH_WR_LOW   = 4'd7,
		PH_WR_HIGH  = 4'd8,
		PH_WR_GAP   = 4'd9
	} phase_t;

endpackage

/* rtl/core/one_wire_bus_master_top.sv */
// one-wire bus master: tick stream in, bus drive and status stream out
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata: write_data, bus_level; s_tuser: cmd_valid, func
// m_*       out  m_tvalid/m_tready  m_tdata: bus_pull_low, busy, done, device_absent, read_data
// apb       in   psel/penable       eight 10-bit timing registers at byte address 4*i
//
// one word per cycle while m_tready does not stall; each word passes an input register
// and then a result register, from which its result is sent
// the phase, tick counter, bit index and shift byte update in the result stage
// arst_n clears the pipeline valids, the controller state and loads the default timings
// a stall on m_tready holds both stages; s_tready drops only when both are full
module one_wire_bus_master_top #(
	parameter int COUNT_WIDTH = owbm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [7:0] write_data, [8] bus_level, [15:9] zero
	input  logic [owbm_pkg::S_TDATA_W-1:0]  s_tdata,
	// [0] cmd_valid, [2:1] func
	input  logic [owbm_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] bus_pull_low, [1] busy_res, [2] done_res, [3] device_absent,
	// [11:4] read_data, [15:12] zero
	output logic [owbm_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [owbm_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	localparam int CW = COUNT_WIDTH;
	localparam int WW = (CW > owbm_pkg::REG_W) ? CW : owbm_pkg::REG_W;
	localparam logic [WW-1:0] CMAX_W = WW'((64'd1 << CW) - 64'd1);
	localparam logic [CW-1:0] CMAX   = CMAX_W[CW-1:0];

	owbm_pkg::reg_word_t cfg_q [owbm_pkg::NUM_REGS];

	logic [2:0] cfg_idx;
	logic       cfg_wr;

	logic       v_s1;
	logic       cmd_valid_s1;
	logic [1:0] func_s1;
	logic [7:0] wdata_s1;
	logic       level_s1;

	logic                      m_valid_q;
	logic [owbm_pkg::M_TDATA_W-1:0] m_data_q;
	logic                      adv;

	owbm_pkg::phase_t phase_q, phase_n, ph;
	logic [CW-1:0]    tick_q, tick_n, tc, tc_inc, dur;
	logic [2:0]       bit_q, bit_n;
	logic [7:0]       shift_q, shift_n;
	logic             absent_q, absent_n;
	logic [7:0]       read_q, read_n;
	logic             pull, busy, done;
	owbm_pkg::reg_word_t raw;

	function automatic logic [CW-1:0] clip(input owbm_pkg::reg_word_t r);
		logic [WW-1:0] rw;
		logic [CW-1:0] t;
		begin
			rw = WW'(r);
			if (rw > CMAX_W) t = CMAX;
			else t = rw[CW-1:0];
			if (t == '0) t = CW'(1);
			return t;
		end
	endfunction

	// configuration port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[owbm_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = {{(32 - owbm_pkg::REG_W){1'b0}}, cfg_q[cfg_idx]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= owbm_pkg::REG_DEFAULTS;
		end else if (cfg_wr) begin
			cfg_q[cfg_idx] <= pwdata[owbm_pkg::REG_W-1:0];
		end
	end

	// pipeline control
	assign adv      = !m_valid_q || m_tready;
	assign s_tready = !v_s1 || adv;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_valid_s1 <= s_tuser[0];
			func_s1      <= s_tuser[2:1];
			wdata_s1     <= s_tdata[7:0];
			level_s1     <= s_tdata[8];
		end
	end

	// next state and outputs for the word in the input register
	always_comb begin
		ph    = phase_q;
		tc    = tick_q;
		bit_n = bit_q;
		shift_n = shift_q;
		absent_n = absent_q;
		read_n = read_q;
		done  = 1'b0;

		if (phase_q == owbm_pkg::PH_IDLE && cmd_valid_s1) begin
			unique case (func_s1)
				owbm_pkg::FUNC_RESET: begin
					ph = owbm_pkg::PH_RST_LOW;
					tc = '0;
					bit_n = '0;
				end
				owbm_pkg::FUNC_WRITE: begin
					ph = owbm_pkg::PH_WR_LOW;
					tc = '0;
					bit_n = '0;
					shift_n = wdata_s1;
				end
				owbm_pkg::FUNC_READ: begin
					ph = owbm_pkg::PH_RD_LOW;
					tc = '0;
					bit_n = '0;
					shift_n = '0;
				end
				default: begin
					tc = '0;
					bit_n = '0;
				end
			endcase
		end

		unique case (ph)
			owbm_pkg::PH_RST_LOW:  raw = cfg_q[owbm_pkg::REG_RESET_LOW];
			owbm_pkg::PH_RST_WAIT: raw = cfg_q[owbm_pkg::REG_PRESENCE_SMP];
			owbm_pkg::PH_RST_REC:  raw = cfg_q[owbm_pkg::REG_RESET_REC];
			owbm_pkg::PH_RD_LOW:   raw = cfg_q[owbm_pkg::REG_READ_LOW];
			owbm_pkg::PH_RD_WAIT:  raw = cfg_q[owbm_pkg::REG_READ_SMP];
			owbm_pkg::PH_RD_REC:   raw = cfg_q[owbm_pkg::REG_READ_REC];
			owbm_pkg::PH_WR_LOW:   raw = shift_n[0] ? cfg_q[owbm_pkg::REG_WRITE_SHORT]
			                                        : cfg_q[owbm_pkg::REG_WRITE_LONG];
			owbm_pkg::PH_WR_HIGH:  raw = shift_n[0] ? cfg_q[owbm_pkg::REG_WRITE_LONG]
			                                        : cfg_q[owbm_pkg::REG_WRITE_SHORT];
			default:               raw = owbm_pkg::REG_W'(owbm_pkg::GAP_TICKS);
		endcase
		dur = clip(raw);

		busy = (ph != owbm_pkg::PH_IDLE);
		pull = (ph == owbm_pkg::PH_RST_LOW) || (ph == owbm_pkg::PH_RD_LOW) ||
		       (ph == owbm_pkg::PH_WR_LOW);
		tc_inc  = (tc == CMAX) ? tc : tc + CW'(1);
		phase_n = ph;
		tick_n  = tc;

		if (busy) begin
			tick_n = tc_inc;
			if (tc_inc >= dur) begin
				tick_n = '0;
				unique case (ph)
					owbm_pkg::PH_RST_LOW:  phase_n = owbm_pkg::PH_RST_WAIT;
					owbm_pkg::PH_RST_WAIT: begin
						absent_n = level_s1;
						phase_n  = owbm_pkg::PH_RST_REC;
					end
					owbm_pkg::PH_RST_REC: begin
						done    = 1'b1;
						phase_n = owbm_pkg::PH_IDLE;
					end
					owbm_pkg::PH_RD_LOW:   phase_n = owbm_pkg::PH_RD_WAIT;
					owbm_pkg::PH_RD_WAIT: begin
						shift_n = {level_s1, shift_n[7:1]};
						phase_n = owbm_pkg::PH_RD_REC;
					end
					owbm_pkg::PH_RD_REC: begin
						if (bit_n == 3'd7) begin
							read_n  = shift_n;
							done    = 1'b1;
							phase_n = owbm_pkg::PH_IDLE;
						end else begin
							bit_n   = bit_n + 3'd1;
							phase_n = owbm_pkg::PH_RD_LOW;
						end
					end
					owbm_pkg::PH_WR_LOW:   phase_n = owbm_pkg::PH_WR_HIGH;
					owbm_pkg::PH_WR_HIGH:  phase_n = owbm_pkg::PH_WR_GAP;
					owbm_pkg::PH_WR_GAP: begin
						shift_n = {1'b0, shift_n[7:1]};
						if (bit_n == 3'd7) begin
							done    = 1'b1;
							phase_n = owbm_pkg::PH_IDLE;
						end else begin
							bit_n   = bit_n + 3'd1;
							phase_n = owbm_pkg::PH_WR_LOW;
						end
					end
					default: phase_n = owbm_pkg::PH_IDLE;
				endcase
			end
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= owbm_pkg::PH_IDLE;
			tick_q   <= '0;
			bit_q    <= '0;
			shift_q  <= '0;
			absent_q <= 1'b0;
			read_q   <= '0;
		end else if (adv && v_s1) begin
			phase_q  <= phase_n;
			tick_q   <= tick_n;
			bit_q    <= bit_n;
			shift_q  <= shift_n;
			absent_q <= absent_n;
			read_q   <= read_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			m_data_q <= {4'b0, read_n, absent_n, done, busy, pull};
		end
	end

endmodule
